### rtl/assert_macros.svh
// Assertion helpers for the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define MRFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked implication check, masked while reset is asserted.
`define MRFP_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// Constants for the motor reply frame parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

    localparam int MAX_MOTOR_ID_DEF       = 32;
    localparam int FRAME_BUFFER_BYTES_DEF = 16;

    // Only the header and payload bytes 0..6 are ever parsed.
    localparam int HDR_BYTES = 7;

    localparam logic [7:0] TERM_RESET   = 8'd107;
    localparam logic [7:0] CMD_SPEED    = 8'h0E;
    localparam logic [7:0] CMD_POSITION = 8'h0F;
    localparam int MIN_SPEED_LEN    = 6;
    localparam int MIN_POSITION_LEN = 8;

    localparam int ID_W   = 6;
    localparam int POS_W  = 32;
    localparam int SPD_W  = 17;

    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Frame byte slots.
    localparam int BYTE_ID   = 0;
    localparam int BYTE_CMD  = 1;
    localparam int BYTE_SIGN = 2;
    localparam int BYTE_D0   = 3;
    localparam int BYTE_D1   = 4;
    localparam int BYTE_D2   = 5;
    localparam int BYTE_D3   = 6;

endpackage

### rtl/motor_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_reply_frame_parser
// Collects motor reply bytes into frames and keeps per-motor speed and
// position tables; answers table reads.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transaction per item. s_tuser is the operation (0 = received
//   byte in s_tdata[7:0], 1 = read the tables for motor id in s_tdata[15:8]).
//   m_axis: one result transaction per input transaction, in order.
//   cfg: cfg_valid/cfg_ready write the terminator byte; write only while idle.
// Path: from input transaction to m_tvalid through the table RAM read, then the
// output register. Throughput: one item per cycle while m_tready is high;
// each table has a single registered RAM read, feeding the output register.
// Stall: when m_tready is low the output register and the RAM-read stage
// fill, then s_tready drops; nothing is lost and the output holds.
// Reset: frame count clears, the terminator returns to 107, and per-entry
// valid bits make every table entry read as zero until it is first written.
// A completed frame writes its table in the same cycle it is accepted and the
// result carries the new value forwarded around the RAM.
// ----------------------------------------------------------------------------
module motor_reply_frame_parser
    import mrfp_pkg::*;
#(
    parameter int MAX_MOTOR_ID       = MAX_MOTOR_ID_DEF,
    parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] motor_id
    input  logic        s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [5:0] reply_id, [37:6] position_value,
                                   // [54:38] speed_value, [55] zero
    output logic [1:0]  m_tuser,   // [0] speed_updated, [1] position_updated
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // terminator_byte
);

    `include "assert_macros.svh"

    localparam int DEPTH = MAX_MOTOR_ID + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(FRAME_BUFFER_BYTES + 1);

    // ---------------- configuration ----------------
    logic [7:0] term_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            term_reg <= cfg_data;
        end
    end

    // ---------------- stage 0: frame collection and parse ----------------
    logic          accept;
    logic          op;
    logic [7:0]    rx_byte;
    logic [7:0]    motor_id;
    logic [CW-1:0] count_reg, count_next, count_after;
    logic [7:0]    hdr_reg [HDR_BYTES];
    logic          storing;
    logic          is_term;
    logic          id_ok;
    logic          spd_up, pos_up;
    logic [15:0]   spd_mag;
    logic [31:0]   pos_mag;
    logic [SPD_W-1:0] spd_wval;
    logic [POS_W-1:0] pos_wval;
    logic [AW-1:0] frame_addr, rd_addr;
    logic          rd_emit;
    logic          neg;

    assign op       = s_tuser;
    assign rx_byte  = s_tdata[7:0];
    assign motor_id = s_tdata[15:8];
    assign accept   = s_tvalid && s_tready;

    assign storing     = count_reg < CW'(FRAME_BUFFER_BYTES);
    assign count_after = storing ? count_reg + CW'(1) : '0;
    assign is_term     = rx_byte == term_reg;
    assign id_ok       = hdr_reg[BYTE_ID] <= 8'(MAX_MOTOR_ID);
    assign neg         = hdr_reg[BYTE_SIGN] != 8'd0;

    assign spd_mag  = {hdr_reg[BYTE_D0], hdr_reg[BYTE_D1]};
    assign pos_mag  = {hdr_reg[BYTE_D0], hdr_reg[BYTE_D1], hdr_reg[BYTE_D2], hdr_reg[BYTE_D3]};
    assign spd_wval = neg ? SPD_W'(-{1'b0, spd_mag}) : {1'b0, spd_mag};
    assign pos_wval = neg ? -pos_mag : pos_mag;

    always_comb begin
        spd_up = 1'b0;
        pos_up = 1'b0;
        if (op == OP_RX_BYTE && is_term && count_after >= CW'(MIN_SPEED_LEN) && id_ok) begin
            if (hdr_reg[BYTE_CMD] == CMD_SPEED) begin
                spd_up = 1'b1;
            end else if (hdr_reg[BYTE_CMD] == CMD_POSITION
                         && count_after >= CW'(MIN_POSITION_LEN)) begin
                pos_up = 1'b1;
            end
        end
    end

    assign frame_addr = AW'(hdr_reg[BYTE_ID]);
    assign rd_addr    = (op == OP_READ) ? AW'(motor_id) : frame_addr;
    assign rd_emit    = (op == OP_READ) ? (motor_id <= 8'(MAX_MOTOR_ID)) : (spd_up || pos_up);

    always_comb begin
        count_next = count_reg;
        if (accept && op == OP_RX_BYTE) begin
            count_next = is_term ? '0 : count_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Keep only the bytes the parser looks at.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (accept && op == OP_RX_BYTE && storing && count_reg == CW'(i)) begin
                hdr_reg[i] <= rx_byte;
            end
        end
    end

    // ---------------- tables ----------------
    logic [DEPTH-1:0] spd_vld_reg, pos_vld_reg;
    logic [SPD_W-1:0] spd_rdata;
    logic [POS_W-1:0] pos_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_vld_reg <= '0;
            pos_vld_reg <= '0;
        end else if (accept) begin
            if (spd_up) begin
                spd_vld_reg[frame_addr] <= 1'b1;
            end
            if (pos_up) begin
                pos_vld_reg[frame_addr] <= 1'b1;
            end
        end
    end

    mrfp_ram #(.WIDTH(SPD_W), .DEPTH(DEPTH)) u_spd_ram (
        .aclk  (aclk),
        .we    (accept && spd_up),
        .waddr (frame_addr),
        .wdata (spd_wval),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (spd_rdata)
    );

    mrfp_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_pos_ram (
        .aclk  (aclk),
        .we    (accept && pos_up),
        .waddr (frame_addr),
        .wdata (pos_wval),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (pos_rdata)
    );

    // ---------------- stage 1: RAM data ----------------
    logic             s1_valid_reg;
    logic             s1_spd_up_reg, s1_pos_up_reg, s1_emit_reg;
    logic             s1_spd_vld_reg, s1_pos_vld_reg;
    logic [ID_W-1:0]  s1_id_reg;
    logic [SPD_W-1:0] s1_spd_fwd_reg;
    logic [POS_W-1:0] s1_pos_fwd_reg;
    logic             out_free, s1_move;

    assign out_free = !m_tvalid || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_spd_up_reg  <= spd_up;
            s1_pos_up_reg  <= pos_up;
            s1_emit_reg    <= rd_emit;
            s1_id_reg      <= (op == OP_READ) ? ID_W'(motor_id) : ID_W'(hdr_reg[BYTE_ID]);
            s1_spd_fwd_reg <= spd_wval;
            s1_pos_fwd_reg <= pos_wval;
            s1_spd_vld_reg <= spd_vld_reg[rd_addr];
            s1_pos_vld_reg <= pos_vld_reg[rd_addr];
        end
    end

    // ---------------- output register ----------------
    logic             m_valid_reg;
    logic [1:0]       m_user_reg;
    logic [ID_W-1:0]  m_id_reg;
    logic [SPD_W-1:0] m_spd_reg, spd_out;
    logic [POS_W-1:0] m_pos_reg, pos_out;

    // Forward this item's own write; an entry never written reads as zero.
    always_comb begin
        spd_out = '0;
        pos_out = '0;
        if (s1_emit_reg) begin
            if (s1_spd_up_reg) begin
                spd_out = s1_spd_fwd_reg;
            end else if (s1_spd_vld_reg) begin
                spd_out = spd_rdata;
            end
            if (s1_pos_up_reg) begin
                pos_out = s1_pos_fwd_reg;
            end else if (s1_pos_vld_reg) begin
                pos_out = pos_rdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_user_reg <= {s1_pos_up_reg, s1_spd_up_reg};
            m_id_reg   <= s1_emit_reg ? s1_id_reg : '0;
            m_spd_reg  <= spd_out;
            m_pos_reg  <= pos_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = {1'b0, m_spd_reg, m_pos_reg, m_id_reg};

    // ---------------- assertions ----------------
    `MRFP_ASSERT(a_one_update, !(m_tvalid && m_tuser[0] && m_tuser[1]),
        "speed and position flagged in one result")
    `MRFP_ASSERT(a_count_range, count_reg <= CW'(FRAME_BUFFER_BYTES),
        "frame count beyond buffer size")
    `MRFP_ASSERT_IMPL(a_term_clears, accept && op == OP_RX_BYTE && is_term,
        count_reg == '0, "frame count not cleared after terminator")
    `MRFP_ASSERT_IMPL(a_update_id, s1_move && (s1_spd_up_reg || s1_pos_up_reg),
        m_tvalid && m_tdata[ID_W-1:0] == $past(s1_id_reg), "update result lost its id")

endmodule

### rtl/mrfp_ram.sv
// ----------------------------------------------------------------------------
// mrfp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mrfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
